// ----- rtl/core/bcc_pkg.sv -----
`default_nettype none

package bcc_pkg;

	// Fixed field widths
	localparam int unsigned PIXEL_W     = 8;
	localparam int unsigned CLASS_W     = 2;
	localparam int unsigned COORD_W     = 10;
	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned CFG_INDEX_W = 1;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Pixel classes
	localparam logic [CLASS_W-1:0] CLASS_BACKGROUND = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_OBJECT     = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_BOUNDARY   = 2'd2;

	// Defaults and sizes
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;
	localparam int unsigned DIM_RESET      = 1024;
	localparam int unsigned RES_PER_ITEM   = 3;
	localparam int unsigned QUEUE_DEPTH    = 4;
	localparam int unsigned QCOUNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} result_t;

	// All results caused by one input pixel; slot 0 is emitted first
	typedef struct packed {
		logic [RES_PER_ITEM-1:0] mask;
		result_t [RES_PER_ITEM-1:0] res;
		logic done;
	} bundle_t;

endpackage

`default_nettype wire

// ----- rtl/core/bcc_ram.sv -----
`default_nettype none

module bcc_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/bcc_front.sv -----
`default_nettype none

module bcc_front #(
	parameter int unsigned MAX_WIDTH  = bcc_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bcc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [bcc_pkg::PIXEL_W-1:0]      pixel_value,
	input  logic                             cfg_wr_en,
	input  logic [bcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [bcc_pkg::QCOUNT_W-1:0]     q_count,
	output logic                             bun_push,
	output bcc_pkg::bundle_t                 bun_data
);

	import bcc_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
	localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CNT_W = QCOUNT_W + 1;

	// 0 acts as 1, anything above the maximum acts as the maximum
	function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
			input int unsigned maxv);
		int unsigned r;
		r = 32'(v);
		if (r < 1) begin
			r = 1;
		end else if (r > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	localparam logic [WID_W-1:0] WIDTH_RST  =
		WID_W'(clamp_dim(CFG_DATA_W'(DIM_RESET), MAX_WIDTH));
	localparam logic [HGT_W-1:0] HEIGHT_RST =
		HGT_W'(clamp_dim(CFG_DATA_W'(DIM_RESET), MAX_HEIGHT));

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [8:0]       win_q;
	logic             fwd_q;
	logic [1:0]       fwd_data_q;

	logic             valid_s1;
	logic [COL_W-1:0] x_s1;
	logic [ROW_W-1:0] y_s1;
	logic             cur_s1;
	logic             last_col_s1;
	logic             last_row_s1;

	logic             accept;
	logic             last_col;
	logic             last_row;
	logic [1:0]       ram_rd;
	logic [1:0]       lines;
	logic [1:0]       row_wr;
	logic [2:0]       newcol;
	logic [8:0]       win_new;
	logic             edge_pix;
	logic             nb_zero;
	logic [CLASS_W-1:0] cls_mid;
	logic [COL_W-1:0] cx;
	logic [ROW_W-1:0] cy;
	logic [WID_W-1:0] wlast;

	// room for this item and the one in flight
	assign full = (CNT_W'(q_count) + CNT_W'(valid_s1)) >= CNT_W'(QUEUE_DEPTH);
	assign accept = push && !full;

	assign last_col = (WID_W'(col_q) + WID_W'(1)) >= width_q;
	assign last_row = (HGT_W'(row_q) + HGT_W'(1)) >= height_q;

	// bit 0: row y-1 flag, bit 1: row y-2 flag
	bcc_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (x_s1),
		.wr_data (row_wr),
		.rd_addr (col_q),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= '0;
			win_q    <= '0;
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			// width 1: the next pixel reads the column being written now
			fwd_q    <= valid_s1 && (col_q == x_s1);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_q <= WID_W'(clamp_dim(cfg_data, MAX_WIDTH));
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= HGT_W'(clamp_dim(cfg_data, MAX_HEIGHT));
					end
					default: begin
					end
				endcase
				col_q <= '0;
				row_q <= '0;
				win_q <= '0;
			end else begin
				if (accept) begin
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				if (valid_s1) begin
					win_q <= win_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= row_wr;
		if (accept) begin
			x_s1        <= col_q;
			y_s1        <= row_q;
			cur_s1      <= (pixel_value == '0);
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	always_comb begin
		lines    = fwd_q ? fwd_data_q : ram_rd;
		row_wr   = {lines[0], cur_s1};
		newcol   = {cur_s1, lines[0], lines[1]};
		win_new  = {newcol, win_q[8:3]};
		cx       = x_s1 - COL_W'(1);
		cy       = y_s1 - ROW_W'(1);
		wlast    = width_q - WID_W'(1);
		edge_pix = (x_s1 == COL_W'(1)) || (WID_W'(x_s1) >= width_q)
			|| (y_s1 == ROW_W'(1)) || (HGT_W'(y_s1) >= height_q);
		nb_zero  = (win_new & 9'h1EF) != 9'h000;
		if (win_new[4]) begin
			cls_mid = CLASS_BACKGROUND;
		end else if (edge_pix || nb_zero) begin
			cls_mid = CLASS_BOUNDARY;
		end else begin
			cls_mid = CLASS_OBJECT;
		end

		bun_data.mask[0]    = (y_s1 != '0) && (x_s1 != '0);
		bun_data.mask[1]    = (y_s1 != '0) && last_col_s1;
		bun_data.mask[2]    = last_row_s1;
		bun_data.res[0].cls = cls_mid;
		bun_data.res[0].col = COORD_W'(cx);
		bun_data.res[0].row = COORD_W'(cy);
		bun_data.res[1].cls = lines[0] ? CLASS_BACKGROUND : CLASS_BOUNDARY;
		bun_data.res[1].col = COORD_W'(wlast);
		bun_data.res[1].row = COORD_W'(cy);
		bun_data.res[2].cls = cur_s1 ? CLASS_BACKGROUND : CLASS_BOUNDARY;
		bun_data.res[2].col = COORD_W'(x_s1);
		bun_data.res[2].row = COORD_W'(y_s1);
		bun_data.done       = last_row_s1 && last_col_s1;
		bun_push            = valid_s1 && (bun_data.mask != '0);
	end

endmodule

`default_nettype wire

// ----- rtl/core/bcc_queue.sv -----
`default_nettype none

module bcc_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  bcc_pkg::bundle_t             wr_data,
	input  logic                         rd_en,
	output bcc_pkg::bundle_t             rd_data,
	output logic                         not_empty,
	output logic [bcc_pkg::QCOUNT_W-1:0] count
);

	import bcc_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	bundle_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;
	logic             do_rd;

	assign not_empty = count_q != '0;
	assign count     = count_q;
	assign rd_data   = mem_q[rd_ptr_q];
	assign do_rd     = rd_en && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !do_rd) begin
				count_q <= count_q + QCOUNT_W'(1);
			end else if (do_rd && !wr_en) begin
				count_q <= count_q - QCOUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bcc_back.sv -----
`default_nettype none

module bcc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  bcc_pkg::bundle_t             q_data,
	output logic                         q_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [bcc_pkg::CLASS_W-1:0]  pixel_class,
	output logic [bcc_pkg::COORD_W-1:0]  out_col,
	output logic [bcc_pkg::COORD_W-1:0]  out_row,
	output logic                         last_of_run,
	output logic                         frame_done
);

	import bcc_pkg::*;

	localparam logic [1:0] SLOT_LAST_ROW = 2'd2;

	bundle_t                 bun_q;
	logic [RES_PER_ITEM-1:0] bmask_q;
	logic                    out_valid_q;
	logic [CLASS_W-1:0]      class_q;
	logic [COORD_W-1:0]      col_q;
	logic [COORD_W-1:0]      row_q;
	logic                    last_q;
	logic                    done_q;

	logic [1:0]              sel;
	logic [RES_PER_ITEM-1:0] rem;
	logic                    have;
	logic                    out_free;
	logic                    take;

	always_comb begin
		if (bmask_q[0]) begin
			sel = 2'd0;
			rem = {bmask_q[2:1], 1'b0};
		end else if (bmask_q[1]) begin
			sel = 2'd1;
			rem = {bmask_q[2], 2'b00};
		end else begin
			sel = SLOT_LAST_ROW;
			rem = 3'b000;
		end
		have     = bmask_q != '0;
		out_free = !out_valid_q || pop;
		take     = have && out_free;
		q_pop    = q_valid && (!have || (take && (rem == '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmask_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				bmask_q <= q_data.mask;
			end else if (take) begin
				bmask_q <= rem;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bun_q <= q_data;
		end
		if (take) begin
			class_q <= bun_q.res[sel].cls;
			col_q   <= bun_q.res[sel].col;
			row_q   <= bun_q.res[sel].row;
			last_q  <= rem == '0;
			done_q  <= (sel == SLOT_LAST_ROW) && bun_q.done;
		end
	end

	assign empty       = !out_valid_q;
	assign pixel_class = class_q;
	assign out_col     = col_q;
	assign out_row     = row_q;
	assign last_of_run = last_q;
	assign frame_done  = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/binary_contour_classifier.sv -----
// Path: a pixel's first result passes the line buffer read, classify, queue,
//   bundle register and output register before it shows on the output ports.
// Throughput: one pixel per cycle while pixels average one result; the output drains
//   one result per cycle while pop is held, the queue soaks up row ends, and on the last row
//   (two results per pixel) full paces the input to the rate at which results drain.
// Reset: arst_n clears counters, window, queue and output; line buffers keep
//   their contents and need no clearing pass.
`default_nettype none

module binary_contour_classifier #(
	parameter int unsigned MAX_WIDTH  = bcc_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bcc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel input side
	input  logic                            push,
	output logic                            full,
	input  logic [bcc_pkg::PIXEL_W-1:0]     pixel_value,
	// result side
	output logic                            empty,
	input  logic                            pop,
	output logic [bcc_pkg::CLASS_W-1:0]     pixel_class,
	output logic [bcc_pkg::COORD_W-1:0]     out_col,
	output logic [bcc_pkg::COORD_W-1:0]     out_row,
	output logic                            last_of_run,
	output logic                            frame_done,
	// configuration writes (also restart the frame)
	input  logic                            cfg_wr_en,
	input  logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import bcc_pkg::*;

	// Front: raster counters, line buffers of zero flags, 3x3 window.
	// Every pixel becomes one bundle of up to three results; empty
	// bundles are dropped. The front holds full whenever the queue could
	// not take the bundle of the pixel it would accept, so it never stalls
	// mid-pipe.
	bundle_t             bun_in;
	bundle_t             bun_out;
	logic                bun_push;
	logic                bun_pop;
	logic                bun_avail;
	logic [QCOUNT_W-1:0] bun_count;

	bcc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel_value (pixel_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_count     (bun_count),
		.bun_push    (bun_push),
		.bun_data    (bun_in)
	);

	// Short bundle queue decoupling the pixel stream from the result drain.
	bcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (bun_push),
		.wr_data   (bun_in),
		.rd_en     (bun_pop),
		.rd_data   (bun_out),
		.not_empty (bun_avail),
		.count     (bun_count)
	);

	// Back: unpacks bundles one result per transaction, oldest slot first;
	// the next bundle is loaded in the cycle the last slot is taken.
	bcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (bun_avail),
		.q_data      (bun_out),
		.q_pop       (bun_pop),
		.empty       (empty),
		.pop         (pop),
		.pixel_class (pixel_class),
		.out_col     (out_col),
		.out_row     (out_row),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

`default_nettype wire

// ----- rtl/core/bcc_checker.sv -----
`default_nettype none

module bcc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           empty,
	input logic                           pop,
	input logic [bcc_pkg::CLASS_W-1:0]    pixel_class,
	input logic [bcc_pkg::COORD_W-1:0]    out_col,
	input logic [bcc_pkg::COORD_W-1:0]    out_row,
	input logic                           last_of_run,
	input logic                           frame_done
);

	import bcc_pkg::*;

	// a waiting result stays until taken
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(pixel_class) && $stable(out_col) && $stable(out_row))
		else $error("waiting result changed");

	// the frame's final pixel is always the last result of its transaction
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// object pixels never sit on the left or top edge
	a_object_inner: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (pixel_class == CLASS_OBJECT) |-> (out_col != '0) && (out_row != '0))
		else $error("object pixel on image edge");

endmodule

bind binary_contour_classifier bcc_checker u_bcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.pixel_class (pixel_class),
	.out_col     (out_col),
	.out_row     (out_row),
	.last_of_run (last_of_run),
	.frame_done  (frame_done)
);

`default_nettype wire
